// ===== sv/ncs_pkg.sv =====
// Package for the nearest-center search block.
// Holds sizes, queue word and configuration types shared by all modules.
package ncs_pkg;

  localparam int MAX_CENTERS = 16;
  localparam int MAX_DIMS = 16;
  localparam int COORD_BITS = 16;
  localparam int CIDX_BITS = $clog2(MAX_CENTERS);
  localparam int DIDX_BITS = $clog2(MAX_DIMS);
  localparam int ADDR_BITS = CIDX_BITS + DIDX_BITS;
  localparam int CFG_BITS = 5;
  localparam int DIST_BITS = 36;
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int SQ_BITS = 2 * DIFF_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_BITS-1:0] CENTERS_RESET = CFG_BITS'(0);
  localparam logic [CFG_BITS-1:0] DIMS_RESET = CFG_BITS'(16);
  localparam logic [DIST_BITS-1:0] DIST_NONE = '1;

  typedef enum logic {
    REG_CENTERS = 1'b0,
    REG_DIMS    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_LOAD       = 2'd0,
    KIND_POINT      = 2'd1,
    KIND_POINT_LAST = 2'd2,
    KIND_DROP       = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [CIDX_BITS-1:0]   center_index;
    logic [DIDX_BITS-1:0]   coord_index;
    logic [COORD_BITS-1:0]  coord_value;
  } entry_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] centers;
    logic [CFG_BITS-1:0] dims;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_t;

endpackage

// ===== sv/ncs_if.sv =====
// Channel interfaces of the nearest-center search block.
// Depends on ncs_pkg for field widths.
interface ncs_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [3:0]                      center_index;
  logic [3:0]                      coord_index;
  logic signed [ncs_pkg::COORD_BITS-1:0] coord_value;

  modport source (output valid, action, center_index, coord_index, coord_value, input ready);
  modport sink (input valid, action, center_index, coord_index, coord_value, output ready);
endinterface

interface ncs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [3:0]                     nearest_index;
  logic [ncs_pkg::DIST_BITS-1:0]  min_sq_distance;

  modport source (output valid, found, nearest_index, min_sq_distance, input ready);
  modport sink (input valid, found, nearest_index, min_sq_distance, output ready);
endinterface

// ===== sv/nearest_center_search_unit.sv =====
// Top level of the nearest-center search block.
// Depends on ncs_pkg, ncs_if, ncs_front, ncs_queue and ncs_back.
//
// Words arrive on the items channel. A word with action 0 writes one
// coordinate of one center into the center store; a word with action 1
// writes one coordinate of the current point. The point coordinate whose
// index is dims_in_use-1 starts a search over all centers in use, and one
// word leaves on the results channel with the nearest index and the squared
// distance. The cfg port writes centers_in_use (index 0) and dims_in_use
// (index 1); the user must do so only while the block is idle, which the
// block does not enforce. The front takes one word per cycle into a
// four-word queue, unless the queue is full. The back retires a load or
// plain point word as it pops it. A search runs the center store through a
// four-stage subtract, square and accumulate pipeline, one coordinate per
// cycle; with no centers the result appears next cycle.
// The result sits in an output register; a stalled receiver holds it, and
// the back does not start the next search until it is taken. Reset clears
// the queue, the pipeline, the output register and the configuration
// registers (centers 0, dims 16); the stores hold no reset value.
module nearest_center_search_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ncs_pkg::CFG_BITS-1:0] cfg_data,
  ncs_in_if.sink                       items,
  ncs_out_if.source                    results
);

  ncs_pkg::q_status_t q_status;
  ncs_pkg::entry_t    push_entry;
  ncs_pkg::entry_t    head;
  ncs_pkg::cfg_t      cfg;
  logic               push;
  logic               pop;

  ncs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .items      (items),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry),
    .cfg        (cfg)
  );

  ncs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  ncs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .results  (results)
  );

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("word taken from an empty queue");

  a_search_waits: assert property (@(posedge clk) disable iff (rst)
    pop && head.kind == ncs_pkg::KIND_POINT_LAST |-> !results.valid)
    else $error("search started while a result is still pending");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.found |->
      results.nearest_index == '0 && results.min_sq_distance == ncs_pkg::DIST_NONE)
    else $error("empty search result is malformed");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !items.ready)
    else $error("input accepted into a full queue");
`endif

endmodule

// ===== sv/ncs_front.sv =====
// Front end: configuration registers, input acceptance and item classification.
// Depends on ncs_pkg and ncs_in_if.
module ncs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ncs_pkg::CFG_BITS-1:0] cfg_data,
  ncs_in_if.sink                       items,
  input  ncs_pkg::q_status_t           q_status,
  output logic                         push,
  output ncs_pkg::entry_t              push_entry,
  output ncs_pkg::cfg_t                cfg
);

  logic [ncs_pkg::CFG_BITS-1:0] centers_reg;
  logic [ncs_pkg::CFG_BITS-1:0] dims_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      centers_reg <= ncs_pkg::CENTERS_RESET;
      dims_reg <= ncs_pkg::DIMS_RESET;
    end else if (cfg_we) begin
      unique case (ncs_pkg::reg_index_t'(cfg_index))
        ncs_pkg::REG_CENTERS: centers_reg <= cfg_data;
        ncs_pkg::REG_DIMS:    dims_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.centers = (centers_reg > ncs_pkg::CFG_BITS'(ncs_pkg::MAX_CENTERS)) ?
                  ncs_pkg::CFG_BITS'(ncs_pkg::MAX_CENTERS) : centers_reg;
    if (dims_reg == '0) begin
      cfg.dims = ncs_pkg::CFG_BITS'(1);
    end else if (dims_reg > ncs_pkg::CFG_BITS'(ncs_pkg::MAX_DIMS)) begin
      cfg.dims = ncs_pkg::CFG_BITS'(ncs_pkg::MAX_DIMS);
    end else begin
      cfg.dims = dims_reg;
    end
  end

  assign items.ready = !q_status.full;
  assign push = items.valid && items.ready;

  always_comb begin
    push_entry.center_index = items.center_index[ncs_pkg::CIDX_BITS-1:0];
    push_entry.coord_index = items.coord_index[ncs_pkg::DIDX_BITS-1:0];
    push_entry.coord_value = items.coord_value;
    if (!items.action) begin
      push_entry.kind = (int'(items.center_index) < ncs_pkg::MAX_CENTERS &&
                         int'(items.coord_index) < ncs_pkg::MAX_DIMS) ?
                        ncs_pkg::KIND_LOAD : ncs_pkg::KIND_DROP;
    end else if (int'(items.coord_index) >= ncs_pkg::MAX_DIMS) begin
      push_entry.kind = ncs_pkg::KIND_DROP;
    end else if (ncs_pkg::CFG_BITS'(items.coord_index) == cfg.dims - ncs_pkg::CFG_BITS'(1)) begin
      push_entry.kind = ncs_pkg::KIND_POINT_LAST;
    end else begin
      push_entry.kind = ncs_pkg::KIND_POINT;
    end
  end

endmodule

// ===== sv/ncs_queue.sv =====
// Short first-in first-out queue of classified words between front and back.
// Depends on ncs_pkg.
module ncs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ncs_pkg::entry_t     push_entry,
  input  logic                pop,
  output ncs_pkg::entry_t     head,
  output ncs_pkg::q_status_t  q_status
);

  ncs_pkg::entry_t slots [ncs_pkg::QUEUE_DEPTH];
  logic [ncs_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [ncs_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [ncs_pkg::QPTR_BITS:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head = slots[rd_ptr];
  assign q_status.full = (count == (ncs_pkg::QPTR_BITS+1)'(ncs_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

endmodule

// ===== sv/ncs_back.sv =====
// Back end: center store, point buffer, pipelined distance search and result register.
// Depends on ncs_pkg and ncs_out_if.
module ncs_back (
  input  logic                clk,
  input  logic                rst,
  input  ncs_pkg::cfg_t       cfg,
  input  ncs_pkg::entry_t     head,
  input  ncs_pkg::q_status_t  q_status,
  output logic                pop,
  ncs_out_if.source           results
);

  logic [ncs_pkg::COORD_BITS-1:0] center_mem [ncs_pkg::MAX_CENTERS * ncs_pkg::MAX_DIMS];
  logic [ncs_pkg::COORD_BITS-1:0] point_buf [ncs_pkg::MAX_DIMS];

  ncs_pkg::back_state_t state;
  logic                           issuing;
  logic [ncs_pkg::CIDX_BITS-1:0]  issue_c;
  logic [ncs_pkg::DIDX_BITS-1:0]  issue_d;
  logic                           issue_last_d;
  logic                           issue_last_c;

  logic                           a_valid;
  logic                           a_first_d, a_last_d, a_last_c;
  logic [ncs_pkg::CIDX_BITS-1:0]  a_c;
  logic [ncs_pkg::COORD_BITS-1:0] mem_q;
  logic [ncs_pkg::COORD_BITS-1:0] p_q;

  logic                           b_valid;
  logic                           b_first_d, b_last_d, b_last_c;
  logic [ncs_pkg::CIDX_BITS-1:0]  b_c;
  logic [ncs_pkg::DIFF_BITS-1:0]  absd;

  logic                           c_valid;
  logic                           c_first_d, c_last_d, c_last_c;
  logic [ncs_pkg::CIDX_BITS-1:0]  c_c;
  logic [ncs_pkg::SQ_BITS-1:0]    sq;

  logic [ncs_pkg::DIST_BITS-1:0]  acc;
  logic [ncs_pkg::DIST_BITS-1:0]  best_d;
  logic [ncs_pkg::CIDX_BITS-1:0]  best_i;

  logic                           out_valid;
  logic                           out_found;
  logic [3:0]                     out_index;
  logic [ncs_pkg::DIST_BITS-1:0]  out_dist;

  logic [ncs_pkg::DIFF_BITS-1:0]  diff;
  logic [ncs_pkg::DIST_BITS:0]    sum_wide;
  logic [ncs_pkg::DIST_BITS-1:0]  acc_sum;
  logic                           better;
  logic                           finish;

  assign pop = (state == ncs_pkg::ST_IDLE) && !q_status.empty &&
               (head.kind != ncs_pkg::KIND_POINT_LAST || !out_valid);

  assign issue_last_d = (ncs_pkg::CFG_BITS'(issue_d) == cfg.dims - ncs_pkg::CFG_BITS'(1));
  assign issue_last_c = (ncs_pkg::CFG_BITS'(issue_c) == cfg.centers - ncs_pkg::CFG_BITS'(1));

  assign diff = {p_q[ncs_pkg::COORD_BITS-1], p_q} - {mem_q[ncs_pkg::COORD_BITS-1], mem_q};
  assign sum_wide = {1'b0, acc} + (ncs_pkg::DIST_BITS+1)'(sq);

  always_comb begin
    if (c_first_d) begin
      acc_sum = ncs_pkg::DIST_BITS'(sq);
    end else if (sum_wide[ncs_pkg::DIST_BITS]) begin
      acc_sum = ncs_pkg::DIST_NONE;
    end else begin
      acc_sum = sum_wide[ncs_pkg::DIST_BITS-1:0];
    end
  end

  assign better = (c_c == '0) || (acc_sum < best_d);
  assign finish = c_valid && c_last_d && c_last_c;

  always_ff @(posedge clk) begin
    if (pop && head.kind == ncs_pkg::KIND_LOAD) begin
      center_mem[{head.center_index, head.coord_index}] <= head.coord_value;
    end
    mem_q <= center_mem[{issue_c, issue_d}];
  end

  always_ff @(posedge clk) begin
    if (pop && (head.kind == ncs_pkg::KIND_POINT || head.kind == ncs_pkg::KIND_POINT_LAST)) begin
      point_buf[head.coord_index] <= head.coord_value;
    end
    p_q <= point_buf[issue_d];
  end

  always_ff @(posedge clk) begin
    a_first_d <= (issue_d == '0);
    a_last_d <= issue_last_d;
    a_last_c <= issue_last_c;
    a_c <= issue_c;
    b_first_d <= a_first_d;
    b_last_d <= a_last_d;
    b_last_c <= a_last_c;
    b_c <= a_c;
    absd <= diff[ncs_pkg::DIFF_BITS-1] ? -diff : diff;
    c_first_d <= b_first_d;
    c_last_d <= b_last_d;
    c_last_c <= b_last_c;
    c_c <= b_c;
    sq <= absd * absd;
    if (c_valid) begin
      acc <= acc_sum;
      if (c_last_d && better) begin
        best_d <= acc_sum;
        best_i <= c_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncs_pkg::ST_IDLE;
      issuing <= 1'b0;
      issue_c <= '0;
      issue_d <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid <= issuing;
      b_valid <= a_valid;
      c_valid <= b_valid;
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (issuing) begin
        if (issue_last_d) begin
          issue_d <= '0;
          issue_c <= issue_c + 1'b1;
          if (issue_last_c) begin
            issuing <= 1'b0;
          end
        end else begin
          issue_d <= issue_d + 1'b1;
        end
      end
      unique case (state)
        ncs_pkg::ST_IDLE: begin
          if (pop && head.kind == ncs_pkg::KIND_POINT_LAST) begin
            if (cfg.centers == '0) begin
              out_valid <= 1'b1;
              out_found <= 1'b0;
              out_index <= '0;
              out_dist <= ncs_pkg::DIST_NONE;
            end else begin
              state <= ncs_pkg::ST_RUN;
              issuing <= 1'b1;
              issue_c <= '0;
              issue_d <= '0;
            end
          end
        end
        ncs_pkg::ST_RUN: begin
          if (finish) begin
            state <= ncs_pkg::ST_IDLE;
            out_valid <= 1'b1;
            out_found <= 1'b1;
            out_index <= better ? 4'(c_c) : 4'(best_i);
            out_dist <= better ? acc_sum : best_d;
          end
        end
        default: state <= ncs_pkg::ST_IDLE;
      endcase
    end
  end

  assign results.valid = out_valid;
  assign results.found = out_found;
  assign results.nearest_index = out_index;
  assign results.min_sq_distance = out_dist;

endmodule
